>>> rtl/bsr_pkg.sv
// bsr_pkg: shared types and constants of the bisection root search block
// fixed point data width, iteration counter width, result kind codes,
// request/result payload structs and the search state struct
package bsr_pkg;

  // signed Q16.16 data, iteration counter, configuration widths
  localparam int DATA_WIDTH    = 32;
  localparam int ITER_WIDTH    = 16;
  localparam int TOL_WIDTH     = 31;
  localparam int CFG_IDX_WIDTH = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ITER_LIMIT = 1'd1;

  // configuration reset values
  localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RST  = 31'd1;
  localparam logic [ITER_WIDTH-1:0] ITER_LIMIT_RST = 16'd1000;

  // request types
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_ROOT  = 2'd1;
  localparam logic [1:0] KIND_LIMIT = 2'd2;
  localparam logic [1:0] KIND_IDLE  = 2'd3;

  // input request payload
  typedef struct packed {
    logic                         req_type;
    logic signed [DATA_WIDTH-1:0] left_end;
    logic signed [DATA_WIDTH-1:0] right_end;
    logic signed [DATA_WIDTH-1:0] value_left;
    logic signed [DATA_WIDTH-1:0] value_right;
    logic signed [DATA_WIDTH-1:0] probe_value;
  } in_t;

  // result payload
  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] point;
    logic [DATA_WIDTH-1:0]        error_estimate;
    logic [ITER_WIDTH-1:0]        iterations;
  } out_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [TOL_WIDTH-1:0]  tolerance;
    logic [ITER_WIDTH-1:0] iter_limit;
  } cfg_t;

  // bracket and iteration state of the running search
  typedef struct packed {
    logic [DATA_WIDTH-1:0] left_point;
    logic [DATA_WIDTH-1:0] right_point;
    logic [DATA_WIDTH-1:0] left_value;
    logic [DATA_WIDTH-1:0] current_probe;
    logic [ITER_WIDTH-1:0] iter_count;
    logic                  active;
  } state_t;

endpackage

>>> rtl/bsr_step.sv
// bsr_step: combinational single-request step of the bisection search
// takes the registered request, configuration and search state, gives the
// next state and the result; depends on bsr_pkg
module bsr_step (
  input  bsr_pkg::cfg_t   cfg_i,
  input  bsr_pkg::state_t state_i,
  input  bsr_pkg::in_t    req_i,
  output bsr_pkg::state_t state_o,
  output bsr_pkg::out_t   res_o
);
  import bsr_pkg::*;

  // magnitude of a signed value, exact as unsigned
  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // floor((a+b)/2) without overflow
  function automatic logic [DATA_WIDTH-1:0] mid(input logic [DATA_WIDTH-1:0] a,
                                                input logic [DATA_WIDTH-1:0] b);
    logic [DATA_WIDTH:0] s;
    s   = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    mid = s[DATA_WIDTH:1];
  endfunction

  // bracket width |b-a|
  function automatic logic [DATA_WIDTH-1:0] span(input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
    span = ($signed(b) >= $signed(a)) ? (b - a) : (a - b);
  endfunction

  logic [DATA_WIDTH-1:0] tol;
  logic [DATA_WIDTH-1:0] mag_fa;
  logic [DATA_WIDTH-1:0] mag_fb;
  logic [DATA_WIDTH-1:0] mag_fc;
  logic [DATA_WIDTH-1:0] width;
  logic [DATA_WIDTH-1:0] new_left;
  logic [DATA_WIDTH-1:0] new_right;
  logic [ITER_WIDTH-1:0] cnt_inc;
  logic                  cnt_sat;
  logic                  move_right;

  // shared arithmetic
  assign tol    = {{(DATA_WIDTH-TOL_WIDTH){1'b0}}, cfg_i.tolerance};
  assign mag_fa = mag(req_i.value_left);
  assign mag_fb = mag(req_i.value_right);
  assign mag_fc = mag(req_i.probe_value);
  assign width  = span(state_i.left_point, state_i.right_point);

  // sign test: right end moves on a strict sign change
  assign move_right = (req_i.probe_value != '0) && (state_i.left_value != '0) &&
                      (req_i.probe_value[DATA_WIDTH-1] != state_i.left_value[DATA_WIDTH-1]);
  assign new_left  = move_right ? state_i.left_point : state_i.current_probe;
  assign new_right = move_right ? state_i.current_probe : state_i.right_point;

  // saturating iteration count
  assign cnt_sat = &state_i.iter_count;
  assign cnt_inc = cnt_sat ? state_i.iter_count : state_i.iter_count + 1'b1;

  // request decode and result selection
  always_comb begin
    state_o              = state_i;
    res_o.kind           = KIND_IDLE;
    res_o.point          = '0;
    res_o.error_estimate = '0;
    res_o.iterations     = state_i.iter_count;
    if (req_i.req_type == REQ_START) begin
      state_o.iter_count = '0;
      state_o.active     = 1'b0;
      res_o.iterations   = '0;
      if (mag_fa < tol) begin
        res_o.kind           = KIND_ROOT;
        res_o.point          = req_i.left_end;
        res_o.error_estimate = mag_fa;
      end else if (mag_fb < tol) begin
        res_o.kind           = KIND_ROOT;
        res_o.point          = req_i.right_end;
        res_o.error_estimate = mag_fb;
      end else if (cfg_i.iter_limit == '0) begin
        res_o.kind           = KIND_LIMIT;
        res_o.error_estimate = span(req_i.left_end, req_i.right_end);
      end else begin
        state_o.left_point    = req_i.left_end;
        state_o.right_point   = req_i.right_end;
        state_o.left_value    = req_i.value_left;
        state_o.current_probe = mid(req_i.left_end, req_i.right_end);
        state_o.active        = 1'b1;
        res_o.kind            = KIND_PROBE;
        res_o.point           = state_o.current_probe;
      end
    end else if (state_i.active) begin
      if ((mag_fc < tol) || (width < tol)) begin
        // converged on |f| or on bracket width
        state_o.active       = 1'b0;
        res_o.kind           = KIND_ROOT;
        res_o.point          = state_i.current_probe;
        res_o.error_estimate = (mag_fc < width) ? mag_fc : width;
      end else begin
        state_o.left_point  = new_left;
        state_o.right_point = new_right;
        if (!move_right) begin
          state_o.left_value = req_i.probe_value;
        end
        state_o.iter_count = cnt_inc;
        res_o.iterations   = cnt_inc;
        if ((cnt_inc >= cfg_i.iter_limit) || (&cnt_inc)) begin
          state_o.active       = 1'b0;
          res_o.kind           = KIND_LIMIT;
          res_o.point          = state_i.current_probe;
          res_o.error_estimate = span(new_left, new_right);
        end else begin
          state_o.current_probe = mid(new_left, new_right);
          res_o.kind            = KIND_PROBE;
          res_o.point           = state_o.current_probe;
        end
      end
    end
  end

endmodule

>>> rtl/bisection_root_search.sv
// bisection_root_search: top level of the bisection root search controller
// request register, bsr_step logic, result register and configuration;
// depends on bsr_pkg and bsr_step
//
// Bisection root search in signed Q16.16. The function is evaluated outside:
// a start request brings the bracket and f at both ends, each later request
// brings f at the last probe point, and every request gives exactly one
// result (probe, root, iteration limit, or value without a search). The
// block takes one request per clock cycle without gaps while the result side
// accepts results. A taken request sits in the request register; once the
// result register is free or being emptied, the step logic loads its result
// into the result register, from which it is offered to the output.
// The step logic reads the bracket state and the registered request and
// writes the new state in the same cycle the result register loads. Both
// sides may stall freely; no clearing pass is needed after reset. Write the
// tolerance and the iteration limit only while no request is in flight.
module bisection_root_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bsr_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bsr_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bsr_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [bsr_pkg::TOL_WIDTH-1:0]       cfg_wdata_i
);
  import bsr_pkg::*;

  logic   in_valid_q;
  in_t    in_data_q;
  logic   out_valid_q;
  out_t   out_data_q;
  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;
  out_t   res_d;
  logic   advance;

  // request moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance  <= TOLERANCE_RST;
      cfg_q.iter_limit <= ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOLERANCE:  cfg_q.tolerance  <= cfg_wdata_i;
        CFG_ITER_LIMIT: cfg_q.iter_limit <= cfg_wdata_i[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // request register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // request register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // step logic
  bsr_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (in_data_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // a probe result leaves a search running
  a_probe_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.kind == KIND_PROBE)) |=> state_q.active)
    else $error("probe issued without active search");

  // a root or limit result ends the search
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ((res_d.kind == KIND_ROOT) || (res_d.kind == KIND_LIMIT)))
      |=> !state_q.active)
    else $error("search still active after final result");

  // a value without search is only reported while idle
  a_idle_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.kind == KIND_IDLE)) |-> !state_q.active)
    else $error("idle result during active search");

  // an active search never holds a saturated count
  a_count_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.active |-> !(&state_q.iter_count))
    else $error("active search with saturated iteration count");

  // back pressure only comes from a held request
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a held request");
`endif

endmodule
